[hw/rtl/fla_pkg.sv]
// fla_pkg: shared types and codes of the free list node allocator.
// No dependencies; used by fla_ctrl, fla_dp, free_list_node_allocator and the testbench.
package fla_pkg;

  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FRESH_W  = SLOT_W + 1;
  localparam int SLOT_SPACE = 1 << SLOT_W;

  typedef enum logic {
    CMD_GET    = 1'b0,
    CMD_RETURN = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_GRANTED   = 2'd0,
    STS_RETURNED  = 2'd1,
    STS_EXHAUSTED = 2'd2
  } status_t;

  // one link memory entry: next slot plus end-of-list flag
  typedef struct packed {
    logic              last;
    logic [SLOT_W-1:0] next;
  } link_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic pop_done;  // head link read back, finish the pop
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_lookup;  // presented item is a get served from the free list
  } dp_sts_t;

endpackage

[hw/rtl/fla_ctrl.sv]
// fla_ctrl: handshake controller of the allocator.
// Depends on fla_pkg; drives fla_dp through dp_cmd_t, reads dp_sts_t.
module fla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fla_pkg::dp_cmd_t cmd,
  input  fla_pkg::dp_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd.accept   = accept;
  assign cmd.pop_done = (state_r == ST_LOOKUP);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.need_lookup) begin
            state_nxt = ST_LOOKUP;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_lookup_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |-> !in_ready)
    else $error("input taken during head lookup");

  a_lookup_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("head lookup did not produce a result");

  a_pop_enters_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.need_lookup) |=> (state_r == ST_LOOKUP))
    else $error("free list get did not start a lookup");

endmodule

[hw/rtl/fla_dp.sv]
// fla_dp: allocator datapath: link memory, list head, bump counter, result register.
// Depends on fla_pkg; controlled by fla_ctrl.
module fla_dp #(
  parameter int POOL_NODES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fla_pkg::dp_cmd_t                cmd,
  output fla_pkg::dp_sts_t                sts,
  input  logic                            in_command,
  input  logic [fla_pkg::SLOT_W-1:0]      in_node_slot,
  output logic [fla_pkg::SLOT_W-1:0]      out_granted_slot,
  output logic [fla_pkg::STATUS_W-1:0]    out_status
);

  localparam int FRESH_LIMIT =
    (POOL_NODES < fla_pkg::SLOT_SPACE) ? POOL_NODES : fla_pkg::SLOT_SPACE;
  localparam logic [fla_pkg::FRESH_W-1:0] FRESH_MAX = fla_pkg::FRESH_W'(FRESH_LIMIT);

  fla_pkg::link_t link_mem [fla_pkg::SLOT_SPACE];
  fla_pkg::link_t rd_link_r;

  logic [fla_pkg::SLOT_W-1:0]   head_r, head_nxt;
  logic                         nonempty_r, nonempty_nxt;
  logic [fla_pkg::FRESH_W-1:0]  fresh_r, fresh_nxt;
  logic [fla_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [fla_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                         is_return;
  logic                         wr_en;
  fla_pkg::link_t               wr_link;

  assign is_return = (fla_pkg::cmd_t'(in_command) == fla_pkg::CMD_RETURN);
  assign sts.need_lookup = !is_return && nonempty_r;

  assign wr_en        = cmd.accept && is_return;
  assign wr_link.next = head_r;
  assign wr_link.last = !nonempty_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[in_node_slot] <= wr_link;
    end
    rd_link_r <= link_mem[head_r];
  end

  always_comb begin
    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    fresh_nxt    = fresh_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    if (cmd.pop_done) begin
      slot_nxt     = head_r;
      status_nxt   = fla_pkg::STS_GRANTED;
      head_nxt     = rd_link_r.next;
      nonempty_nxt = !rd_link_r.last;
    end else if (cmd.accept) begin
      if (is_return) begin
        head_nxt     = in_node_slot;
        nonempty_nxt = 1'b1;
        slot_nxt     = '0;
        status_nxt   = fla_pkg::STS_RETURNED;
      end else if (!nonempty_r) begin
        if (fresh_r < FRESH_MAX) begin
          slot_nxt   = fresh_r[fla_pkg::SLOT_W-1:0];
          status_nxt = fla_pkg::STS_GRANTED;
          fresh_nxt  = fresh_r + 1'b1;
        end else begin
          slot_nxt   = '0;
          status_nxt = fla_pkg::STS_EXHAUSTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      nonempty_r <= 1'b0;
      fresh_r    <= '0;
    end else begin
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      fresh_r    <= fresh_nxt;
    end
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
  end

  assign out_granted_slot = slot_r;
  assign out_status       = status_r;

  a_fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= FRESH_MAX)
    else $error("bump counter beyond pool");

  a_return_fills_list: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && is_return) |=> nonempty_r && (status_r == fla_pkg::STS_RETURNED))
    else $error("return did not push onto free list");

  a_pop_grants_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_done |=> (slot_r == $past(head_r)) && (status_r == fla_pkg::STS_GRANTED))
    else $error("pop did not grant list head");

endmodule

[hw/rtl/free_list_node_allocator.sv]
// Free list node allocator: grants node slots from a linked free list of
// returned slots, then from a bump counter bounded by POOL_NODES (at most 256),
// and answers exhausted when both are empty. One result per command. A return,
// a bump-counter get and an exhausted get reach the output register in the
// cycle after the item is taken; a get served from the free list first passes
// through the head lookup state, because the link memory read that fetches the
// next head is registered, and then reaches the output register. A new item
// is taken once that register is empty or being drained in the same cycle and
// no head lookup is under way. The link memory needs no clearing after reset.
// Depends on fla_pkg, fla_ctrl and fla_dp.
module free_list_node_allocator #(
  parameter int POOL_NODES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [fla_pkg::SLOT_W-1:0]    in_node_slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fla_pkg::SLOT_W-1:0]    out_granted_slot,
  output logic [fla_pkg::STATUS_W-1:0]  out_status
);

  fla_pkg::dp_cmd_t dp_cmd;
  fla_pkg::dp_sts_t dp_sts;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  fla_dp #(
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .in_command       (in_command),
    .in_node_slot     (in_node_slot),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

endmodule

[sim/testbench.sv]
// testbench: randomized check of free_list_node_allocator against a slot-level predictor.
// Mixes get and return commands with random handshake gaps and one long output stall.
// Depends on fla_pkg and the allocator RTL.
`timescale 1ns / 100ps

typedef struct {
  logic [fla_pkg::SLOT_W-1:0] slot;
  fla_pkg::status_t           status;
} alloc_result_t;

class alloc_scoreboard;
  logic [fla_pkg::SLOT_W-1:0] next_link [fla_pkg::SLOT_SPACE];
  bit                         last_link [fla_pkg::SLOT_SPACE];
  logic [fla_pkg::SLOT_W-1:0] head;
  bit                         nonempty;
  int unsigned                fresh_count;
  int unsigned                fresh_limit;
  alloc_result_t              awaited [$];
  int unsigned                mismatches;
  int unsigned                n_granted;
  int unsigned                n_returned;
  int unsigned                n_exhausted;

  function new(int unsigned pool);
    fresh_limit = (pool < fla_pkg::SLOT_SPACE) ? pool : fla_pkg::SLOT_SPACE;
    head        = '0;
    nonempty    = 0;
    fresh_count = 0;
    mismatches  = 0;
    n_granted   = 0;
    n_returned  = 0;
    n_exhausted = 0;
  endfunction

  // predicts the result of an accepted item and queues it
  function alloc_result_t note_input(fla_pkg::cmd_t cmd, logic [fla_pkg::SLOT_W-1:0] slot);
    alloc_result_t r;
    r.slot   = '0;
    if (cmd == fla_pkg::CMD_RETURN) begin
      next_link[slot] = head;
      last_link[slot] = !nonempty;
      head            = slot;
      nonempty        = 1;
      r.status        = fla_pkg::STS_RETURNED;
    end else if (nonempty) begin
      r.slot   = head;
      nonempty = !last_link[head];
      head     = next_link[head];
      r.status = fla_pkg::STS_GRANTED;
    end else if (fresh_count < fresh_limit) begin
      r.slot      = fresh_count[fla_pkg::SLOT_W-1:0];
      fresh_count = fresh_count + 1;
      r.status    = fla_pkg::STS_GRANTED;
    end else begin
      r.status = fla_pkg::STS_EXHAUSTED;
    end
    awaited.push_back(r);
    return r;
  endfunction

  function void check_result(logic [fla_pkg::SLOT_W-1:0] slot,
                             logic [fla_pkg::STATUS_W-1:0] status);
    alloc_result_t e;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result slot=%0d status=%0d", $time, slot, status);
      mismatches++;
      return;
    end
    e = awaited.pop_front();
    if (slot !== e.slot) begin
      $display("%0t: granted_slot expected %0d actual %0d", $time, e.slot, slot);
      mismatches++;
    end
    if (status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      mismatches++;
    end
    case (e.status)
      fla_pkg::STS_GRANTED:  n_granted++;
      fla_pkg::STS_RETURNED: n_returned++;
      default:               n_exhausted++;
    endcase
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction
endclass

module testbench;
  localparam int POOL = 256;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_command;
  logic [fla_pkg::SLOT_W-1:0]   in_node_slot;
  logic                         out_valid;
  logic                         out_ready;
  logic [fla_pkg::SLOT_W-1:0]   out_granted_slot;
  logic [fla_pkg::STATUS_W-1:0] out_status;

  alloc_scoreboard            sb;
  logic [fla_pkg::SLOT_W-1:0] held_slots [$];
  bit                         send_burst;
  bit                         hold_req;
  bit                         reset_done;

  free_list_node_allocator #(.POOL_NODES(POOL)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_node_slot     (in_node_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

  always #4 clk = ~clk;

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input fla_pkg::cmd_t cmd, input logic [fla_pkg::SLOT_W-1:0] slot);
    int            gap;
    alloc_result_t r;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_node_slot <= slot;
    do @(posedge clk); while (!in_ready);
    r = sb.note_input(cmd, slot);
    if (cmd == fla_pkg::CMD_GET && r.status == fla_pkg::STS_GRANTED)
      held_slots.push_back(r.slot);
  endtask

  // get_pct: share of gets; returns mostly give back held slots, else any slot
  task automatic random_phase(input int n_items, input int get_pct);
    int                         idx;
    logic [fla_pkg::SLOT_W-1:0] slot;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < get_pct) begin
        send_item(fla_pkg::CMD_GET, fla_pkg::SLOT_W'($urandom));
      end else if (held_slots.size() > 0 && $urandom_range(0, 99) < 85) begin
        idx  = $urandom_range(0, held_slots.size() - 1);
        slot = held_slots[idx];
        held_slots.delete(idx);
        send_item(fla_pkg::CMD_RETURN, slot);
      end else begin
        send_item(fla_pkg::CMD_RETURN, fla_pkg::SLOT_W'($urandom));
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    int n_seen;
    bit recv_burst;
    n_seen     = 0;
    recv_burst = 0;
    out_ready <= 1'b0;
    wait (reset_done);
    forever begin
      if (n_seen % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        hold_req = 0;
        gap      = 120;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_granted_slot, out_status);
      n_seen++;
    end
  end

  initial begin
    sb           = new(POOL);
    send_burst   = 0;
    hold_req     = 0;
    reset_done   = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= fla_pkg::CMD_GET;
    in_node_slot <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reset_done = 1;

    // directed: bump gets, returns of slots never granted, double return
    send_item(fla_pkg::CMD_GET, 8'h00);
    send_item(fla_pkg::CMD_GET, 8'hFF);
    send_item(fla_pkg::CMD_RETURN, 8'hFF);
    send_item(fla_pkg::CMD_RETURN, 8'h00);
    send_item(fla_pkg::CMD_GET, 8'h00);
    send_item(fla_pkg::CMD_GET, 8'hFF);
    send_item(fla_pkg::CMD_GET, 8'hAA);
    send_item(fla_pkg::CMD_RETURN, 8'h01);
    send_item(fla_pkg::CMD_RETURN, 8'h01);
    send_item(fla_pkg::CMD_GET, 8'h00);
    send_item(fla_pkg::CMD_GET, 8'h55);
    send_item(fla_pkg::CMD_RETURN, 8'hAA);
    send_item(fla_pkg::CMD_RETURN, 8'h55);
    send_item(fla_pkg::CMD_RETURN, 8'h80);
    send_item(fla_pkg::CMD_GET, 8'h7F);
    send_item(fla_pkg::CMD_GET, 8'h00);
    send_item(fla_pkg::CMD_GET, 8'hFF);
    send_item(fla_pkg::CMD_GET, 8'h00);
    send_item(fla_pkg::CMD_RETURN, 8'h7F);
    send_item(fla_pkg::CMD_GET, 8'h01);
    held_slots.delete();

    // drain past the bump limit, then mixed, then return-heavy
    random_phase(350, 95);
    hold_req = 1;
    random_phase(400, 50);
    random_phase(350, 35);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d grants, %0d returns, %0d exhausted answers; %0d bump slots used.",
             sb.n_granted, sb.n_returned, sb.n_exhausted, sb.fresh_count);
    $display("Random handshake gaps on both sides and one long output stall.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/fla_pkg.sv
hw/rtl/fla_ctrl.sv
hw/rtl/fla_dp.sv
hw/rtl/free_list_node_allocator.sv
sim/testbench.sv
